FILE: sv/tsmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsmp_pkg
// Shared types and constants of the multi-policy thread scheduler.
// ----------------------------------------------------------------------------
package tsmp_pkg;

	localparam int MAX_THREADS   = 16;
	localparam int PENDING_DEPTH = 16;
	localparam int SLOT_W        = $clog2(MAX_THREADS);
	localparam int PEND_W        = $clog2(PENDING_DEPTH);
	localparam int REM_W         = 20;
	localparam int ID_W          = 16;
	localparam int TIME_W        = 32;

	localparam logic [2:0] OP_ADD_NOW  = 3'd0;
	localparam logic [2:0] OP_ADD_AT   = 3'd1;
	localparam logic [2:0] OP_START    = 3'd2;
	localparam logic [2:0] OP_EXPIRED  = 3'd3;
	localparam logic [2:0] OP_YIELD    = 3'd4;
	localparam logic [2:0] OP_FINISHED = 3'd5;

	localparam logic [2:0] POL_RR1  = 3'd0;
	localparam logic [2:0] POL_RRN  = 3'd1;
	localparam logic [2:0] POL_FCFS = 3'd2;
	localparam logic [2:0] POL_SJF  = 3'd3;
	localparam logic [2:0] POL_PSJF = 3'd4;

	localparam logic [1:0] CFG_POLICY = 2'd0;
	localparam logic [1:0] CFG_RR     = 2'd1;
	localparam logic [1:0] CFG_SLICE  = 2'd2;

	typedef struct packed {
		logic              load;
		logic              clr;
		logic              wr_next;
		logic              wr_rem;
		logic [7:0]        handle;
		logic [ID_W-1:0]   id;
		logic [REM_W-1:0]  rem;
		logic [TIME_W-1:0] start;
		logic [SLOT_W-1:0] nxt;
	} rc_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [7:0]        handle;
		logic [ID_W-1:0]   id;
		logic [REM_W-1:0]  rem;
		logic [TIME_W-1:0] start;
		logic [SLOT_W-1:0] nxt;
	} rc_state_t;

	typedef struct packed {
		logic              load;
		logic              clr;
		logic [7:0]        handle;
		logic [REM_W-1:0]  rem;
		logic [TIME_W-1:0] at;
	} pc_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [7:0]        handle;
		logic [REM_W-1:0]  rem;
		logic [TIME_W-1:0] at;
	} pc_state_t;

	typedef struct packed {
		logic              table_full;
		logic              all_done;
		logic [TIME_W-1:0] exit_ticks;
		logic [ID_W-1:0]   exit_id;
		logic              exit_valid;
		logic [7:0]        run_slice;
		logic [ID_W-1:0]   run_id;
		logic [7:0]        run_handle;
		logic              run_valid;
	} result_t;

endpackage

FILE: sv/tsmp_ready_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsmp_ready_cell
// One slot of the ready ring: thread fields and the ring link.
// ----------------------------------------------------------------------------
module tsmp_ready_cell import tsmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rc_cmd_t   cmd,
	output rc_state_t st
);

	logic              valid_q;
	logic [7:0]        handle_q;
	logic [ID_W-1:0]   id_q;
	logic [REM_W-1:0]  rem_q;
	logic [TIME_W-1:0] start_q;
	logic [SLOT_W-1:0] nxt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= 1'b1;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			handle_q <= cmd.handle;
			id_q     <= cmd.id;
			start_q  <= cmd.start;
		end
		if (cmd.load || cmd.wr_rem) begin
			rem_q <= cmd.rem;
		end
		if (cmd.load || cmd.wr_next) begin
			nxt_q <= cmd.nxt;
		end
	end

	assign st = '{valid: valid_q, handle: handle_q, id: id_q, rem: rem_q,
		start: start_q, nxt: nxt_q};

endmodule

FILE: sv/tsmp_pend_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsmp_pend_cell
// One entry of the pending arrival list.
// ----------------------------------------------------------------------------
module tsmp_pend_cell import tsmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pc_cmd_t   cmd,
	output pc_state_t st
);

	logic              valid_q;
	logic [7:0]        handle_q;
	logic [REM_W-1:0]  rem_q;
	logic [TIME_W-1:0] at_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= 1'b1;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			handle_q <= cmd.handle;
			rem_q    <= cmd.rem;
			at_q     <= cmd.at;
		end
	end

	assign st = '{valid: valid_q, handle: handle_q, rem: rem_q, at: at_q};

endmodule

FILE: sv/thread_scheduler_multi_policy_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_scheduler_multi_policy_core
// Multi-policy thread scheduler over a ready ring and a pending arrival list.
// ----------------------------------------------------------------------------
// Each event gives exactly one result transaction. An add goes from idle
// straight to the finish state; a start passes the dispatch state first,
// after a walk of the ring under the shortest-job policies; a running event
// (slice expired, yield, finished) sweeps the pending list, then posts and
// dispatches (posts alone when the ring empties), with a walk of the ring
// between when one is needed: the pending list is swept one entry a cycle and
// the ring is walked one link a cycle through a shared compare unit. A new
// event is taken once the previous one has been handed to the output register.
module thread_scheduler_multi_policy_core import tsmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode, thread_handle, budget_quanta, add_time, ticks_used, zero fill
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// run_valid, run_handle, run_id, run_slice, exit_valid, exit_id,
	// exit_ticks, all_done, table_full, zero fill
	output logic [87:0] m_tdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_POST  = 3'd2;
	localparam logic [2:0] ST_PICK  = 3'd3;
	localparam logic [2:0] ST_DISP  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	rc_cmd_t   rcmd [MAX_THREADS];
	rc_state_t rst  [MAX_THREADS];
	pc_cmd_t   pcmd [PENDING_DEPTH];
	pc_state_t pst  [PENDING_DEPTH];

	for (genvar g = 0; g < MAX_THREADS; g++) begin : g_ready
		tsmp_ready_cell u_cell (.clk(clk), .arst_n(arst_n), .cmd(rcmd[g]), .st(rst[g]));
	end
	for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_pend
		tsmp_pend_cell u_cell (.clk(clk), .arst_n(arst_n), .cmd(pcmd[g]), .st(pst[g]));
	end

	logic [2:0]        st_q, st_d;
	logic [2:0]        op_q, op_d;
	logic              leaving_q, leaving_d;
	logic [SLOT_W-1:0] c_q, c_d, cur_q, cur_d, t_q, t_d, best_q, best_d;
	logic [PEND_W-1:0] i_q, i_d, k_q, k_d;
	logic              blocked_q, blocked_d, sjf_q, sjf_d;
	logic [TIME_W-1:0] time_q, time_d;
	logic [ID_W-1:0]   nid_q, nid_d;
	logic [3:0]        sc_q, sc_d;
	logic              started_q, started_d;
	result_t           res_q, res_d;
	logic [2:0]        policy_q;
	logic [3:0]        rr_q;
	logic [7:0]        slice_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [MAX_THREADS-1:0]   rv;
	logic [PENDING_DEPTH-1:0] pv;
	logic                     empty, full, pfull;
	logic [SLOT_W-1:0]        free_s, pred_cur, pred_c;
	logic [PEND_W-1:0]        pfree;

	logic [2:0]        in_op;
	logic [7:0]        in_handle;
	logic [9:0]        in_budget;
	logic [TIME_W-1:0] in_at;
	logic [7:0]        in_ticks;
	logic [REM_W-1:0]  in_rem;

	assign in_op     = s_tdata[2:0];
	assign in_handle = s_tdata[10:3];
	assign in_budget = s_tdata[20:11];
	assign in_at     = s_tdata[52:21];
	assign in_ticks  = s_tdata[60:53];
	assign in_rem    = REM_W'(in_budget) * REM_W'(slice_q);

	always_comb begin
		free_s   = '0;
		pred_cur = cur_q;
		pred_c   = c_q;
		pfree    = '0;
		for (int n = MAX_THREADS - 1; n >= 0; n--) begin
			rv[n] = rst[n].valid;
			if (!rst[n].valid) free_s = SLOT_W'(n);
			if (rst[n].valid && rst[n].nxt == cur_q) pred_cur = SLOT_W'(n);
			if (rst[n].valid && rst[n].nxt == c_q) pred_c = SLOT_W'(n);
		end
		for (int n = PENDING_DEPTH - 1; n >= 0; n--) begin
			pv[n] = pst[n].valid;
			if (!pst[n].valid) pfree = PEND_W'(n);
		end
		empty = ~|rv;
		full  = &rv;
		pfull = &pv;
	end

	function automatic logic [7:0] slice_of(input logic [REM_W-1:0] r, input logic [7:0] s);
		return (r < REM_W'(s)) ? r[7:0] : s;
	endfunction

	logic              ins_req;
	logic [7:0]        ins_h;
	logic [REM_W-1:0]  ins_r;
	logic [3:0]        sc_inc;
	logic              yielded, better;

	always_comb begin
		st_d = st_q; op_d = op_q; leaving_d = leaving_q; c_d = c_q; cur_d = cur_q;
		t_d = t_q; best_d = best_q; i_d = i_q; k_d = k_q; blocked_d = blocked_q;
		sjf_d = sjf_q; time_d = time_q; nid_d = nid_q; sc_d = sc_q;
		started_d = started_q; res_d = res_q;
		ins_req = 1'b0; ins_h = '0; ins_r = '0;
		for (int n = 0; n < MAX_THREADS; n++) rcmd[n] = '0;
		for (int n = 0; n < PENDING_DEPTH; n++) pcmd[n] = '0;
		sc_inc  = sc_q + 4'd1;
		yielded = (op_q == OP_YIELD);
		if (sjf_q) begin
			better = (rst[t_q].rem < rst[best_q].rem) ||
				(rst[t_q].rem == rst[best_q].rem && rst[t_q].id < rst[best_q].id);
		end else begin
			better = rst[t_q].id < rst[best_q].id;
		end

		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_d  = in_op;
					res_d = '0;
					st_d  = ST_FIN;
					unique case (in_op)
						OP_ADD_NOW: begin
							ins_req = 1'b1; ins_h = in_handle; ins_r = in_rem;
							res_d.table_full = full;
						end
						OP_ADD_AT: begin
							if (pfull) begin
								res_d.table_full = 1'b1;
							end else begin
								pcmd[pfree] = '{load: 1'b1, clr: 1'b0, handle: in_handle,
									rem: in_rem, at: in_at};
							end
						end
						OP_START: begin
							if (!started_q && !empty) begin
								if (policy_q == POL_SJF || policy_q == POL_PSJF) begin
									best_d = cur_q; t_d = rst[cur_q].nxt; sjf_d = 1'b1;
									st_d = ST_PICK;
								end else begin
									st_d = ST_DISP;
								end
							end
						end
						OP_EXPIRED, OP_YIELD, OP_FINISHED: begin
							if (started_q) begin
								c_d = cur_q;
								leaving_d = (in_op == OP_FINISHED) ||
									(REM_W'(in_ticks) >= rst[cur_q].rem);
								if (in_op != OP_FINISHED) begin
									rcmd[cur_q].wr_rem = 1'b1;
									rcmd[cur_q].rem = (REM_W'(in_ticks) >= rst[cur_q].rem) ?
										'0 : rst[cur_q].rem - REM_W'(in_ticks);
								end
								time_d = time_q + TIME_W'(in_ticks);
								i_d = '0; k_d = '0; blocked_d = 1'b0;
								st_d = ST_DRAIN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if (pst[i_q].valid) begin
					pcmd[i_q].clr = 1'b1;
					if (!blocked_q && time_q >= pst[i_q].at && !full) begin
						ins_req = 1'b1; ins_h = pst[i_q].handle; ins_r = pst[i_q].rem;
					end else begin
						if (!blocked_q && time_q >= pst[i_q].at) blocked_d = 1'b1;
						pcmd[k_q] = '{load: 1'b1, clr: 1'b0, handle: pst[i_q].handle,
							rem: pst[i_q].rem, at: pst[i_q].at};
						k_d = k_q + 1'b1;
					end
				end
				i_d = i_q + 1'b1;
				if (i_q == PEND_W'(PENDING_DEPTH - 1)) st_d = ST_POST;
			end
			ST_POST: begin
				if (leaving_q) begin
					res_d.exit_valid = 1'b1;
					res_d.exit_id    = rst[c_q].id;
					res_d.exit_ticks = time_q - rst[c_q].start;
				end
				if (leaving_q && rst[c_q].nxt == c_q) begin
					rcmd[c_q].clr = 1'b1;
					started_d = 1'b0;
					res_d.all_done = 1'b1;
					st_d = ST_FIN;
				end else begin
					sc_d = sc_inc;
					st_d = ST_DISP;
					priority case (policy_q)
						POL_RRN: begin
							if (leaving_q || yielded || sc_inc == rr_q) begin
								sc_d = '0; cur_d = rst[cur_q].nxt;
							end
						end
						POL_FCFS, POL_SJF: begin
							if (leaving_q) begin
								best_d = rst[cur_q].nxt; t_d = rst[cur_q].nxt;
								sjf_d = (policy_q == POL_SJF); st_d = ST_PICK;
							end
						end
						POL_PSJF: begin
							best_d = leaving_q ? rst[cur_q].nxt : cur_q;
							t_d = rst[cur_q].nxt; sjf_d = 1'b1; st_d = ST_PICK;
						end
						default: cur_d = rst[cur_q].nxt;
					endcase
				end
			end
			ST_PICK: begin
				if (t_q == cur_q) begin
					cur_d = best_q;
					st_d = ST_DISP;
				end else begin
					if (better) best_d = t_q;
					t_d = rst[t_q].nxt;
				end
			end
			ST_DISP: begin
				if (op_q == OP_START) begin
					started_d = 1'b1;
				end else if (leaving_q) begin
					rcmd[pred_c].wr_next = 1'b1;
					rcmd[pred_c].nxt = rst[c_q].nxt;
					rcmd[c_q].clr = 1'b1;
				end
				res_d.run_valid  = 1'b1;
				res_d.run_handle = rst[cur_q].handle;
				res_d.run_id     = rst[cur_q].id;
				res_d.run_slice  = slice_of(rst[cur_q].rem, slice_q);
				st_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase

		if (ins_req && !full) begin
			rcmd[free_s].load   = 1'b1;
			rcmd[free_s].handle = ins_h;
			rcmd[free_s].rem    = ins_r;
			rcmd[free_s].start  = time_q;
			rcmd[free_s].id     = nid_q;
			nid_d = nid_q + 1'b1;
			if (empty) begin
				rcmd[free_s].nxt = free_s;
				cur_d = free_s;
			end else begin
				rcmd[free_s].nxt = cur_q;
				rcmd[pred_cur].wr_next = 1'b1;
				rcmd[pred_cur].nxt = free_s;
			end
		end
	end

	assign s_tready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; cur_q <= '0; time_q <= '0; nid_q <= 16'd1;
			sc_q <= '0; started_q <= 1'b0;
			policy_q <= POL_RR1; rr_q <= 4'd3; slice_q <= 8'd5;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d; cur_q <= cur_d; time_q <= time_d; nid_q <= nid_d;
			sc_q <= sc_d; started_q <= started_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POLICY: policy_q <= cfg_data[2:0];
					CFG_RR:     rr_q <= cfg_data[3:0];
					CFG_SLICE:  slice_q <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == ST_FIN && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d; leaving_q <= leaving_d; c_q <= c_d; t_q <= t_d; best_q <= best_d;
		i_q <= i_d; k_q <= k_d; blocked_q <= blocked_d; sjf_q <= sjf_d; res_q <= res_d;
		if (st_q == ST_FIN && (!out_valid_q || m_tready)) out_q <= res_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_q};

	a_started_ring: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> |rv) else $error("started with empty ring");
	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PICK |-> rv[t_q] && rv[best_q]) else $error("ring walk left ring");
	a_disp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DISP |-> rv[cur_q]) else $error("dispatch of free slot");
	a_exit_moved: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DISP && op_q != OP_START && leaving_q |-> cur_q != c_q)
		else $error("exiting thread dispatched");

endmodule

FILE: tb/thread_scheduler_multi_policy_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_scheduler_multi_policy_core_tb
// Self-checking bench for the multi-policy thread scheduler: a queue-fed
// driver and a monitor against a built-in scheduler model, over phases with
// different policy, quantum and rotation settings, random stalls on both sides.
// ----------------------------------------------------------------------------
module thread_scheduler_multi_policy_core_tb;
	import tsmp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;

	thread_scheduler_multi_policy_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// scheduler model state
	logic [2:0]  m_policy;
	logic [3:0]  m_rr;
	logic [7:0]  m_slice;
	logic        rv [MAX_THREADS];
	logic [7:0]  rh [MAX_THREADS];
	logic [15:0] rid [MAX_THREADS];
	logic [31:0] rrem [MAX_THREADS];
	logic [31:0] rst [MAX_THREADS];
	logic [3:0]  rnx [MAX_THREADS];
	logic        pv [PENDING_DEPTH];
	logic [7:0]  ph [PENDING_DEPTH];
	logic [31:0] prem [PENDING_DEPTH];
	logic [31:0] pt [PENDING_DEPTH];
	logic [3:0]  cur;
	logic [31:0] systime;
	logic [15:0] nid;
	logic [3:0]  scount;
	logic        running;

	logic [63:0]  stim_q [$];
	result_t      expected_q [$];
	int           errors = 0;
	int           n_results = 0;
	int           n_dispatch = 0;
	int           n_exit = 0;
	int           n_full = 0;
	int           cycles = 0;
	bit           rx_hold = 0;
	bit           src_noidle = 0;
	bit           dst_noidle = 0;

	function automatic logic ring_is_empty();
		for (int i = 0; i < MAX_THREADS; i++)
			if (rv[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [3:0] pred_of(logic [3:0] s);
		for (int i = 0; i < MAX_THREADS; i++)
			if (rv[i] && rnx[i] == s)
				return i[3:0];
		return s;
	endfunction

	function automatic logic ring_add(logic [7:0] h, logic [31:0] rem);
		logic e;
		int s;
		logic [3:0] p;
		e = ring_is_empty();
		s = MAX_THREADS;
		for (int i = MAX_THREADS - 1; i >= 0; i--)
			if (!rv[i])
				s = i;
		if (s >= MAX_THREADS)
			return 1'b0;
		rh[s] = h;
		rrem[s] = rem;
		rst[s] = systime;
		rid[s] = nid;
		nid = nid + 16'd1;
		if (e) begin
			rnx[s] = s[3:0];
			cur = s[3:0];
		end else begin
			p = pred_of(cur);
			rnx[p] = s[3:0];
			rnx[s] = cur;
		end
		rv[s] = 1'b1;
		return 1'b1;
	endfunction

	function automatic void admit_arrivals();
		int k;
		logic blocked;
		k = 0;
		blocked = 0;
		for (int i = 0; i < PENDING_DEPTH; i++) begin
			if (pv[i]) begin
				pv[i] = 1'b0;
				if (!blocked && systime >= pt[i]) begin
					if (ring_add(ph[i], prem[i]))
						continue;
					blocked = 1;
				end
				ph[k] = ph[i];
				prem[k] = prem[i];
				pt[k] = pt[i];
				pv[k] = 1'b1;
				k++;
			end
		end
	endfunction

	function automatic logic [3:0] choose(logic incl, logic by_id);
		logic [3:0] best, t;
		logic better;
		best = incl ? cur : rnx[cur];
		t = rnx[cur];
		for (int n = 0; n < MAX_THREADS && t != cur; n++) begin
			if (by_id)
				better = rid[t] < rid[best];
			else if (rrem[t] != rrem[best])
				better = rrem[t] < rrem[best];
			else
				better = rid[t] < rid[best];
			if (better)
				best = t;
			t = rnx[t];
		end
		return best;
	endfunction

	function automatic void next_decision(logic exited, logic yielded);
		scount = scount + 4'd1;
		case (m_policy)
			POL_RRN: begin
				if (exited || yielded || scount == m_rr) begin
					scount = 0;
					cur = rnx[cur];
				end
			end
			POL_FCFS: begin
				if (exited)
					cur = choose(1'b0, 1'b1);
			end
			POL_SJF: begin
				if (exited)
					cur = choose(1'b0, 1'b0);
			end
			POL_PSJF: cur = choose(!exited, 1'b0);
			default: cur = rnx[cur];
		endcase
	endfunction

	function automatic void fill_dispatch(ref result_t r);
		r.run_valid = 1'b1;
		r.run_handle = rh[cur];
		r.run_id = rid[cur];
		r.run_slice = (rrem[cur] < {24'd0, m_slice}) ? rrem[cur][7:0] : m_slice;
	endfunction

	function automatic result_t predict_event(logic [63:0] d);
		result_t r;
		logic [2:0] op;
		logic [7:0] h, tk;
		logic [9:0] bq;
		logic [31:0] at;
		logic [3:0] c, p;
		logic leaving;
		int i;
		op = d[2:0];
		h = d[10:3];
		bq = d[20:11];
		at = d[52:21];
		tk = d[60:53];
		r = '0;
		case (op)
			OP_ADD_NOW: begin
				if (!ring_add(h, bq * m_slice))
					r.table_full = 1'b1;
			end
			OP_ADD_AT: begin
				i = PENDING_DEPTH;
				for (int j = PENDING_DEPTH - 1; j >= 0; j--)
					if (!pv[j])
						i = j;
				if (i >= PENDING_DEPTH)
					r.table_full = 1'b1;
				else begin
					ph[i] = h;
					prem[i] = bq * m_slice;
					pt[i] = at;
					pv[i] = 1'b1;
				end
			end
			OP_START: begin
				if (!running && !ring_is_empty()) begin
					if (m_policy == POL_SJF || m_policy == POL_PSJF)
						cur = choose(1'b1, 1'b0);
					running = 1'b1;
					fill_dispatch(r);
				end
			end
			OP_EXPIRED, OP_YIELD, OP_FINISHED: begin
				if (running) begin
					c = cur;
					leaving = (op == OP_FINISHED);
					if (!leaving) begin
						if (tk >= rrem[c]) begin
							rrem[c] = 0;
							leaving = 1;
						end else
							rrem[c] = rrem[c] - tk;
					end
					systime = systime + tk;
					admit_arrivals();
					if (!leaving) begin
						next_decision(1'b0, op == OP_YIELD);
						fill_dispatch(r);
					end else begin
						r.exit_valid = 1'b1;
						r.exit_id = rid[c];
						r.exit_ticks = systime - rst[c];
						if (rnx[c] != c) begin
							next_decision(1'b1, 1'b0);
							p = pred_of(c);
							rnx[p] = rnx[c];
							rv[c] = 1'b0;
							fill_dispatch(r);
						end else begin
							rv[c] = 1'b0;
							running = 1'b0;
							r.all_done = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] pack_event(logic [2:0] op, logic [7:0] h, logic [9:0] bq,
			logic [31:0] at, logic [7:0] tk);
		return {3'd0, tk, at, bq, h, op};
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (stim_q.size() > 0 && (src_noidle || $urandom_range(0, 99) >= 12)) begin
				s_tvalid <= 1'b1;
				s_tdata <= stim_q.pop_front();
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk)
		if (arst_n && s_tvalid && s_tready)
			expected_q.push_back(predict_event(s_tdata));

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !rx_hold && (dst_noidle || $urandom_range(0, 99) >= 12);
	end

	always @(posedge clk) begin
		result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			n_results++;
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (exp_r.run_valid) n_dispatch++;
				if (exp_r.exit_valid) n_exit++;
				if (exp_r.table_full) n_full++;
				if (got.run_valid !== exp_r.run_valid) begin
					$error("run_valid exp %0h got %0h", exp_r.run_valid, got.run_valid);
					errors++;
				end
				if (got.run_handle !== exp_r.run_handle) begin
					$error("run_handle exp %0h got %0h", exp_r.run_handle, got.run_handle);
					errors++;
				end
				if (got.run_id !== exp_r.run_id) begin
					$error("run_id exp %0h got %0h", exp_r.run_id, got.run_id);
					errors++;
				end
				if (got.run_slice !== exp_r.run_slice) begin
					$error("run_slice exp %0h got %0h", exp_r.run_slice, got.run_slice);
					errors++;
				end
				if (got.exit_valid !== exp_r.exit_valid) begin
					$error("exit_valid exp %0h got %0h", exp_r.exit_valid, got.exit_valid);
					errors++;
				end
				if (got.exit_id !== exp_r.exit_id) begin
					$error("exit_id exp %0h got %0h", exp_r.exit_id, got.exit_id);
					errors++;
				end
				if (got.exit_ticks !== exp_r.exit_ticks) begin
					$error("exit_ticks exp %0h got %0h", exp_r.exit_ticks, got.exit_ticks);
					errors++;
				end
				if (got.all_done !== exp_r.all_done) begin
					$error("all_done exp %0h got %0h", exp_r.all_done, got.all_done);
					errors++;
				end
				if (got.table_full !== exp_r.table_full) begin
					$error("table_full exp %0h got %0h", exp_r.table_full, got.table_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (stim_q.size() > 0 || s_tvalid || expected_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POLICY: m_policy = val[2:0];
			CFG_RR: m_rr = val[3:0];
			default: m_slice = val;
		endcase
	endtask

	// one random event, sometimes followed by a start, mostly well-formed scheduling traffic
	task automatic push_random_event(int add_bias);
		int k;
		logic [2:0] op;
		k = $urandom_range(0, 99);
		if (k < add_bias)
			op = OP_ADD_NOW;
		else if (k < add_bias + 12)
			op = OP_ADD_AT;
		else if (k < add_bias + 17)
			op = OP_START;
		else if (k < 97)
			op = 3'(3 + $urandom_range(0, 2));
		else
			op = 3'($urandom_range(6, 7));
		stim_q.push_back(pack_event(op, 8'($urandom),
			($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6)),
			($urandom_range(0, 9) == 0) ? $urandom : systime + $urandom_range(0, 60),
			($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 12))));
		if ($urandom_range(0, 19) == 0)
			stim_q.push_back(pack_event(OP_START, 0, 0, 0, 0));
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		m_policy = POL_RR1;
		m_rr = 4'd3;
		m_slice = 8'd5;
		for (int i = 0; i < MAX_THREADS; i++) begin
			rv[i] = 0; rh[i] = 0; rid[i] = 0; rrem[i] = 0; rst[i] = 0; rnx[i] = 0;
		end
		for (int i = 0; i < PENDING_DEPTH; i++) begin
			pv[i] = 0; ph[i] = 0; prem[i] = 0; pt[i] = 0;
		end
		cur = 0;
		systime = 0;
		nid = 16'd1;
		scount = 0;
		running = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: events before start, extremes, full tables, unknown opcodes
		stim_q.push_back(pack_event(OP_EXPIRED, 0, 0, 0, 8'hFF));
		stim_q.push_back(pack_event(OP_START, 0, 0, 0, 0));
		stim_q.push_back(pack_event(3'd6, 8'hFF, 10'h3FF, 32'hFFFFFFFF, 8'hFF));
		stim_q.push_back(pack_event(3'd7, 0, 0, 0, 0));
		stim_q.push_back(pack_event(OP_ADD_NOW, 8'hFF, 10'h3FF, 0, 0));
		stim_q.push_back(pack_event(OP_ADD_NOW, 8'h00, 10'd0, 0, 0));
		stim_q.push_back(pack_event(OP_ADD_AT, 8'hA5, 10'd2, 32'hFFFFFFFF, 0));
		stim_q.push_back(pack_event(OP_ADD_AT, 8'h5A, 10'd1, 32'd3, 0));
		stim_q.push_back(pack_event(OP_START, 0, 0, 0, 0));
		stim_q.push_back(pack_event(OP_START, 0, 0, 0, 0));
		stim_q.push_back(pack_event(OP_EXPIRED, 0, 0, 0, 8'd4));
		stim_q.push_back(pack_event(OP_YIELD, 0, 0, 0, 8'd0));
		stim_q.push_back(pack_event(OP_EXPIRED, 0, 0, 0, 8'hFF));
		stim_q.push_back(pack_event(OP_FINISHED, 0, 0, 0, 8'd1));
		for (int i = 0; i < 17; i++)
			stim_q.push_back(pack_event(OP_ADD_NOW, 8'(i), 10'(i), 0, 0));
		for (int i = 0; i < 17; i++)
			stim_q.push_back(pack_event(OP_ADD_AT, 8'(i), 10'd1, 32'(i), 0));
		wait_drained();

		// phases over settings, extremes included
		for (int ph_i = 0; ph_i < 9; ph_i++) begin
			case (ph_i)
				0: begin write_reg(CFG_POLICY, 8'(POL_RR1)); write_reg(CFG_SLICE, 8'd1); end
				1: begin write_reg(CFG_POLICY, 8'(POL_RRN)); write_reg(CFG_RR, 8'd1); end
				2: begin write_reg(CFG_RR, 8'd15); write_reg(CFG_SLICE, 8'd255); end
				3: begin write_reg(CFG_RR, 8'd0); write_reg(CFG_SLICE, 8'd0); end
				4: begin write_reg(CFG_POLICY, 8'(POL_FCFS)); write_reg(CFG_SLICE, 8'd7); end
				5: write_reg(CFG_POLICY, 8'(POL_SJF));
				6: begin write_reg(CFG_POLICY, 8'(POL_PSJF)); write_reg(CFG_SLICE, 8'd3); end
				7: write_reg(CFG_POLICY, 8'd7);
				default: begin write_reg(CFG_POLICY, 8'($urandom_range(0, 4)));
					write_reg(CFG_RR, 8'($urandom_range(1, 15))); end
			endcase
			src_noidle = (ph_i == 2);
			dst_noidle = (ph_i == 3);
			for (int n = 0; n < 110; n++)
				push_random_event((ph_i == 8) ? 40 : 25);
			if (ph_i == 5) begin
				// receiver holds off while the sender keeps offering
				rx_hold = 1;
				repeat (300) @(posedge clk);
				rx_hold = 0;
			end
			wait_drained();
		end

		$display("events checked: %0d results, %0d dispatches, %0d exits, %0d refusals",
			n_results, n_dispatch, n_exit, n_full);
		$display("policies rr1, rrn, fcfs, sjf, psjf and an unknown value, quanta 0 to 255");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
